/* src/md5_pkg.sv */
// Shared types, constants and round helper functions for the MD5 stream hasher.
package md5_pkg;

  localparam int MD5_WORDS = 16;

  localparam logic [31:0] MD5_IV_A = 32'h67452301;
  localparam logic [31:0] MD5_IV_B = 32'hEFCDAB89;
  localparam logic [31:0] MD5_IV_C = 32'h98BADCFE;
  localparam logic [31:0] MD5_IV_D = 32'h10325476;

  localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
  localparam logic [5:0] MD5_LAST_POS = 6'd63;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;
  localparam logic [5:0] MD5_LAST_RND = 6'd63;

  localparam logic [31:0] MD5_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // Rotate amounts, indexed by {round group, step within group of four}
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [1:0] {
    BSEL_DATA  = 2'd0,
    BSEL_PAD80 = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } md5_bsel_t;

  typedef struct packed {
    logic      wr_en;
    md5_bsel_t bsel;
    logic      total_inc;
    logic      load;
    logic      round_en;
    logic [5:0] rnd;
    logic [3:0] rd_idx;
    logic      fold;
    logic      finish;
  } md5_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_lt56;
    logic out_free;
  } md5_stat_t;

  // Message word used by a given round
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] lo;
    lo = rnd[3:0];
    case (rnd[5:4])
      2'd0:    md5_g = lo;
      2'd1:    md5_g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    md5_g = 4'(lo * 4'd3 + 4'd5);
      default: md5_g = 4'(lo * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] rnd);
    md5_s = MD5_S[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage

/* src/md5_if.sv */
// Valid/ready channel interfaces for message bytes and digests.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic       end_of_message;

  modport source(output valid, output data_byte, output has_data,
                 output end_of_message, input ready);
  modport sink(input valid, input data_byte, input has_data,
               input end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source(output valid, output digest_a, output digest_b,
                 output digest_c, output digest_d, input ready);
  modport sink(input valid, input digest_a, input digest_b,
               input digest_c, input digest_d, output ready);
endinterface

/* src/md5_dp.sv */
// MD5 datapath: block buffer, counters, chaining words, round unit and digest register.
module md5_dp
  import md5_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  md5_cmd_t         cmd,
  input  logic [7:0]       data_byte,
  output md5_stat_t        stat,
  md5_out_if.source        out_ch
);

  logic [31:0] blk_mem [MD5_WORDS];

  logic [5:0]  fill_r;
  logic [63:0] total_r;
  logic [31:0] ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [31:0] w_r;
  logic [31:0] dig_a_r, dig_b_r, dig_c_r, dig_d_r;
  logic        out_valid_r;

  logic [63:0] len_bits;
  logic [7:0]  wr_byte;
  logic [31:0] f_val, sum_val, rot_val, new_b;
  logic [4:0]  s_amt;

  assign len_bits = {total_r[60:0], 3'b000};

  always_comb begin
    case (cmd.bsel)
      BSEL_DATA:  wr_byte = data_byte;
      BSEL_PAD80: wr_byte = MD5_PAD_BYTE;
      BSEL_LEN:   wr_byte = len_bits[{fill_r[2:0], 3'b000} +: 8];
      default:    wr_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.rnd[5:4])
      2'd0:    f_val = (wb_r & wc_r) | (~wb_r & wd_r);
      2'd1:    f_val = (wb_r & wd_r) | (wc_r & ~wd_r);
      2'd2:    f_val = wb_r ^ wc_r ^ wd_r;
      default: f_val = wc_r ^ (wb_r | ~wd_r);
    endcase
  end

  assign s_amt   = md5_s(cmd.rnd);
  assign sum_val = wa_r + f_val + MD5_K[cmd.rnd] + w_r;
  assign rot_val = (sum_val << s_amt) | (sum_val >> (6'd32 - {1'b0, s_amt}));
  assign new_b   = wb_r + rot_val;

  // Byte lane write; word read feeds the next round
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      blk_mem[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
    w_r <= blk_mem[cmd.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wa_r <= ch_a_r;
      wb_r <= ch_b_r;
      wc_r <= ch_c_r;
      wd_r <= ch_d_r;
    end else if (cmd.round_en) begin
      wa_r <= wd_r;
      wd_r <= wc_r;
      wc_r <= wb_r;
      wb_r <= new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      total_r     <= '0;
      ch_a_r      <= MD5_IV_A;
      ch_b_r      <= MD5_IV_B;
      ch_c_r      <= MD5_IV_C;
      ch_d_r      <= MD5_IV_D;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        fill_r  <= '0;
        total_r <= '0;
        ch_a_r  <= MD5_IV_A;
        ch_b_r  <= MD5_IV_B;
        ch_c_r  <= MD5_IV_C;
        ch_d_r  <= MD5_IV_D;
      end else begin
        if (cmd.wr_en) begin
          fill_r <= fill_r + 6'd1;
        end
        if (cmd.total_inc) begin
          total_r <= total_r + 64'd1;
        end
        if (cmd.fold) begin
          ch_a_r <= ch_a_r + wa_r;
          ch_b_r <= ch_b_r + wb_r;
          ch_c_r <= ch_c_r + wc_r;
          ch_d_r <= ch_d_r + wd_r;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dig_a_r <= ch_a_r;
      dig_b_r <= ch_b_r;
      dig_c_r <= ch_c_r;
      dig_d_r <= ch_d_r;
    end
  end

  assign stat.fill_last = (fill_r == MD5_LAST_POS);
  assign stat.fill_lt56 = (fill_r < MD5_LEN_POS);
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.digest_a = dig_a_r;
  assign out_ch.digest_b = dig_b_r;
  assign out_ch.digest_c = dig_c_r;
  assign out_ch.digest_d = dig_d_r;

  a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ch.ready))
    else $error("digest register overwritten while still pending");

  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !cmd.wr_en)
    else $error("block buffer written during compression");

endmodule

/* src/md5_ctrl.sv */
// MD5 controller: item acceptance, padding sequence and round sequencing.
module md5_ctrl
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  md5_in_if.sink     in_ch,
  input  md5_stat_t  stat,
  output md5_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_FOLD  = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_DONE  = 6'b100000
  } md5_state_t;

  md5_state_t state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       eom_r, eom_nxt;
  logic       pad_r, pad_nxt;
  logic       first_r, first_nxt;
  logic       final_r, final_nxt;
  logic       fire;
  logic [5:0] rd_rnd;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign fire        = in_ch.valid && in_ch.ready;

  // Prefetch the message word of the following round
  assign rd_rnd = (state_r == ST_ROUND) ? rnd_r + 6'd1 : 6'd0;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    eom_nxt   = eom_r;
    pad_nxt   = pad_r;
    first_nxt = first_r;
    final_nxt = final_r;

    cmd           = '0;
    cmd.bsel      = BSEL_DATA;
    cmd.rnd       = rnd_r;
    cmd.rd_idx    = md5_g(rd_rnd);

    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (in_ch.has_data) begin
            cmd.wr_en     = 1'b1;
            cmd.total_inc = 1'b1;
          end
          if (in_ch.has_data && stat.fill_last) begin
            eom_nxt   = in_ch.end_of_message;
            state_nxt = ST_LOAD;
          end else if (in_ch.end_of_message) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.wr_en = 1'b1;
        if (first_r) begin
          cmd.bsel  = BSEL_PAD80;
          first_nxt = 1'b0;
          final_nxt = stat.fill_lt56;
        end else if (final_r && !stat.fill_lt56) begin
          cmd.bsel = BSEL_LEN;
        end else begin
          cmd.bsel = BSEL_ZERO;
        end
        if (stat.fill_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == MD5_LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (pad_r) begin
          if (final_r) begin
            state_nxt = ST_DONE;
          end else begin
            // Length goes into the extra block
            final_nxt = 1'b1;
            state_nxt = ST_PAD;
          end
        end else if (eom_r) begin
          pad_nxt   = 1'b1;
          first_nxt = 1'b1;
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          pad_nxt    = 1'b0;
          eom_nxt    = 1'b0;
          final_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      eom_r   <= 1'b0;
      pad_r   <= 1'b0;
      first_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      eom_r   <= eom_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
    end
  end

  a_load_starts_round0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND && rnd_r == 6'd0))
    else $error("compression did not start at round zero");

  a_last_round_folds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == MD5_LAST_RND) |=> (state_r == ST_FOLD))
    else $error("compression did not end after the last round");

endmodule

/* src/md5_stream_hasher_core.sv */
// Streaming MD5 hasher top level: controller and datapath joined by command and status.
// Message bytes enter one item per accepted cycle on in_ch; an item with end_of_message
// set closes the message and, after padding and the last compression, one 128-bit digest
// appears on out_ch as four little-endian words, after which the block is ready for a new
// message. Every 64th data byte also starts a compression (one word fetch, 64 rounds
// through a single round unit, one chaining add), and no byte is taken until it ends.
// Closing a message writes the padding one byte per cycle up to the block end, then runs
// one compression, or two when 56 or more bytes were buffered, and loads the digest
// register, which may hold a result while the next message streams in.
module md5_stream_hasher_core
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  md5_in_if.sink     in_ch,
  md5_out_if.source  out_ch
);

  md5_cmd_t  cmd;
  md5_stat_t stat;

  md5_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .cmd   (cmd)
  );

  md5_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .stat      (stat),
    .out_ch    (out_ch)
  );

endmodule
